>>> src/usbsre_pkg.sv
// Shared types, codes and constants of the USB device standard request engine.
package usbsre_pkg;

  localparam int unsigned ENDPOINT_COUNT = 8;
  localparam int unsigned EP_IW = $clog2(ENDPOINT_COUNT);

  localparam logic [15:0] ADDR_MASK = 16'h007F;

  typedef enum logic [2:0] {
    ST_UNATTACHED = 3'd0,
    ST_POWERED    = 3'd1,
    ST_DEFAULT    = 3'd2,
    ST_ADDRESSED  = 3'd3,
    ST_CONFIGURED = 3'd4,
    ST_SUSPENDED  = 3'd5
  } dev_state_e;

  typedef enum logic [2:0] {
    RSP_NONE    = 3'd0,
    RSP_ACK     = 3'd1,
    RSP_DATA    = 3'd2,
    RSP_STALL   = 3'd3,
    RSP_FORWARD = 3'd4
  } rsp_e;

  typedef enum logic [2:0] {
    MODE_VBUS    = 3'd0,
    MODE_SUSPEND = 3'd1,
    MODE_WAKEUP  = 3'd2,
    MODE_RESET   = 3'd3,
    MODE_SETUP   = 3'd4
  } mode_e;

  // Standard request codes
  localparam logic [7:0] REQ_GET_STATUS  = 8'h00;
  localparam logic [7:0] REQ_CLEAR_FEAT  = 8'h01;
  localparam logic [7:0] REQ_SET_FEAT    = 8'h03;
  localparam logic [7:0] REQ_SET_ADDRESS = 8'h05;
  localparam logic [7:0] REQ_GET_DESC    = 8'h06;
  localparam logic [7:0] REQ_GET_CONFIG  = 8'h08;
  localparam logic [7:0] REQ_SET_CONFIG  = 8'h09;

  // bmRequestType values
  localparam logic [7:0] RT_DEV_OUT = 8'h00;
  localparam logic [7:0] RT_EP_OUT  = 8'h02;
  localparam logic [7:0] RT_DEV_IN  = 8'h80;
  localparam logic [7:0] RT_IFC_IN  = 8'h81;
  localparam logic [7:0] RT_EP_IN   = 8'h82;

  // Feature selectors
  localparam logic [7:0] FEAT_EP_HALT       = 8'h00;
  localparam logic [7:0] FEAT_REMOTE_WAKEUP = 8'h01;

  // Configuration register indexes
  localparam logic [1:0] CFG_SELF_POWERED = 2'd0;
  localparam logic [1:0] CFG_MAX_CONFIG   = 2'd1;
  localparam logic [1:0] CFG_MANUAL_CLOCK = 2'd2;
  localparam logic [1:0] CFG_EP_ENABLE    = 2'd3;

  typedef struct packed {
    logic [2:0]  mode;
    logic        vbus_present;
    logic [7:0]  request_type;
    logic [7:0]  request_code;
    logic [15:0] request_value;
    logic [15:0] request_index;
  } item_t;

  typedef struct packed {
    dev_state_e  device_state;
    rsp_e        response;
    logic [15:0] reply_data;
    logic [1:0]  reply_length;
    logic [6:0]  device_address;
    logic [7:0]  configuration_number;
    logic        remote_wakeup_enabled;
    logic        pll_enable;
    logic        clock_frozen;
    logic [3:0]  endpoint_reset;
    logic        configure_pulse;
  } result_t;

endpackage

>>> src/usb_device_standard_request_engine.sv
// Top level of the USB device standard request engine.
//
// Input channel (in_valid_i / in_stall_o) carries one bus event per transfer:
// VBUS change, suspend, wakeup, bus reset, or a decoded setup packet.
// Output channel (out_valid_o / out_stall_i) returns exactly one result per
// input transfer: device state, response code, reply word and length, and
// the current address, configuration, wakeup, PLL and clock-freeze levels.
// The configuration port (cfg_we_i, cfg_index_i, cfg_data_i) writes one
// register per cycle. The user must use it only while the block is idle;
// the block itself does not enforce this.
//
// Throughput: one transfer per cycle unless the receiver stalls; the decision
// is a single pass of logic from the input register and the state registers
// into the result register.
//
// Reset puts the device in the unattached state with both stages empty.
// When the receiver stalls, the result register holds; the input register
// takes one more transfer and then in_stall_o rises until the result moves.
module usb_device_standard_request_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  mode_i,
  input  logic        vbus_present_i,
  input  logic [7:0]  request_type_i,
  input  logic [7:0]  request_code_i,
  input  logic [15:0] request_value_i,
  input  logic [15:0] request_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  device_state_o,
  output logic [2:0]  response_o,
  output logic [15:0] reply_data_o,
  output logic [1:0]  reply_length_o,
  output logic [6:0]  device_address_o,
  output logic [7:0]  configuration_number_o,
  output logic        remote_wakeup_enabled_o,
  output logic        pll_enable_o,
  output logic        clock_frozen_o,
  output logic [3:0]  endpoint_reset_o,
  output logic        configure_pulse_o
);

  usbsre_pkg::item_t   in_item, held_item;
  usbsre_pkg::result_t next_result, out_result;
  logic                held_valid;
  logic                out_ready;
  logic                go;

  assign in_item.mode          = mode_i;
  assign in_item.vbus_present  = vbus_present_i;
  assign in_item.request_type  = request_type_i;
  assign in_item.request_code  = request_code_i;
  assign in_item.request_value = request_value_i;
  assign in_item.request_index = request_index_i;

  assign go = held_valid & out_ready;

  usbsre_input_stage u_input (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (in_item),
    .take_i     (out_ready),
    .valid_o    (held_valid),
    .item_o     (held_item)
  );

  usbsre_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .go_i        (go),
    .item_i      (held_item),
    .result_o    (next_result)
  );

  usbsre_output_stage u_output (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (go),
    .result_i    (next_result),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (out_result)
  );

  assign device_state_o          = out_result.device_state;
  assign response_o              = out_result.response;
  assign reply_data_o            = out_result.reply_data;
  assign reply_length_o          = out_result.reply_length;
  assign device_address_o        = out_result.device_address;
  assign configuration_number_o  = out_result.configuration_number;
  assign remote_wakeup_enabled_o = out_result.remote_wakeup_enabled;
  assign pll_enable_o            = out_result.pll_enable;
  assign clock_frozen_o          = out_result.clock_frozen;
  assign endpoint_reset_o        = out_result.endpoint_reset;
  assign configure_pulse_o       = out_result.configure_pulse;

endmodule

>>> src/usbsre_input_stage.sv
// Input register: holds one accepted event or setup transfer for the engine.
module usbsre_input_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  usbsre_pkg::item_t  item_i,
  input  logic               take_i,
  output logic               valid_o,
  output usbsre_pkg::item_t  item_o
);

  logic              vld_q, vld_d;
  usbsre_pkg::item_t item_q;
  logic              accept;

  // Stall only while a held item cannot move on this cycle
  assign in_stall_o = vld_q & ~take_i;
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (take_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

  assign valid_o = vld_q;
  assign item_o  = item_q;

endmodule

>>> src/usbsre_engine.sv
// Device state, configuration registers and the chapter 9 request decision logic.
module usbsre_engine (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [7:0]           cfg_data_i,
  input  logic                 go_i,
  input  usbsre_pkg::item_t    item_i,
  output usbsre_pkg::result_t  result_o
);

  // Configuration registers
  logic       self_powered_q;
  logic [7:0] max_config_q;
  logic       manual_clock_q;
  logic [7:0] ep_enable_q;

  // Device state
  usbsre_pkg::dev_state_e state_q, state_d;
  logic [6:0]  address_q, address_d;
  logic [7:0]  config_q, config_d;
  logic        wakeup_q, wakeup_d;
  logic [usbsre_pkg::ENDPOINT_COUNT-1:0] halt_q, halt_d;
  logic        susp_armed_q, susp_armed_d;
  logic        wake_armed_q, wake_armed_d;
  logic        pll_q, pll_d;
  logic        frozen_q, frozen_d;

  logic [7:0]  val_lo;
  logic [3:0]  ep;
  logic [usbsre_pkg::EP_IW-1:0] ep_sel;
  logic        ep_in_range;
  logic        ep_enabled;

  usbsre_pkg::rsp_e rsp;
  logic [15:0] data;
  logic [1:0]  len;
  logic [3:0]  ep_rst;
  logic        cfg_pulse;

  assign val_lo      = item_i.request_value[7:0];
  assign ep          = item_i.request_index[3:0];
  assign ep_sel      = ep[usbsre_pkg::EP_IW-1:0];
  assign ep_in_range = {1'b0, ep} < 5'(usbsre_pkg::ENDPOINT_COUNT);
  // Mask covers endpoints 0 to 7 only
  assign ep_enabled  = ~ep[3] & ep_enable_q[ep[2:0]];

  always_comb begin
    state_d      = state_q;
    address_d    = address_q;
    config_d     = config_q;
    wakeup_d     = wakeup_q;
    halt_d       = halt_q;
    susp_armed_d = susp_armed_q;
    wake_armed_d = wake_armed_q;
    pll_d        = pll_q;
    frozen_d     = frozen_q;
    rsp          = usbsre_pkg::RSP_NONE;
    data         = 16'h0000;
    len          = 2'd0;
    ep_rst       = 4'd0;
    cfg_pulse    = 1'b0;

    case (item_i.mode)
      usbsre_pkg::MODE_VBUS: begin
        if (item_i.vbus_present) begin
          if (!manual_clock_q) pll_d = 1'b1;
          state_d = usbsre_pkg::ST_POWERED;
        end else begin
          if (!manual_clock_q) pll_d = 1'b0;
          state_d = usbsre_pkg::ST_UNATTACHED;
        end
      end
      usbsre_pkg::MODE_SUSPEND: begin
        if (susp_armed_q) begin
          susp_armed_d = 1'b0;
          wake_armed_d = 1'b1;
          frozen_d     = 1'b1;
          if (!manual_clock_q) pll_d = 1'b0;
          state_d = usbsre_pkg::ST_SUSPENDED;
        end
      end
      usbsre_pkg::MODE_WAKEUP: begin
        if (wake_armed_q) begin
          if (!manual_clock_q) pll_d = 1'b1;
          frozen_d     = 1'b0;
          wake_armed_d = 1'b0;
          susp_armed_d = 1'b1;
          if (config_q != 8'd0) begin
            state_d = usbsre_pkg::ST_CONFIGURED;
          end else if (address_q != 7'd0) begin
            state_d = usbsre_pkg::ST_ADDRESSED;
          end else begin
            state_d = usbsre_pkg::ST_POWERED;
          end
        end
      end
      usbsre_pkg::MODE_RESET: begin
        state_d      = usbsre_pkg::ST_DEFAULT;
        address_d    = 7'd0;
        config_d     = 8'd0;
        halt_d       = '0;
        susp_armed_d = 1'b0;
        wake_armed_d = 1'b1;
      end
      usbsre_pkg::MODE_SETUP: begin
        // Drop setups while unattached
        if (state_q != usbsre_pkg::ST_UNATTACHED) begin
          case (item_i.request_code)
            usbsre_pkg::REQ_GET_STATUS: begin
              if (item_i.request_type == usbsre_pkg::RT_DEV_IN) begin
                data = {14'd0, wakeup_q, self_powered_q};
                len  = 2'd2;
                rsp  = usbsre_pkg::RSP_DATA;
              end else if (item_i.request_type == usbsre_pkg::RT_EP_IN) begin
                if (ep_in_range) begin
                  data = {15'd0, halt_q[ep_sel]};
                  len  = 2'd2;
                  rsp  = usbsre_pkg::RSP_DATA;
                end else begin
                  rsp = usbsre_pkg::RSP_STALL;
                end
              end else begin
                rsp = usbsre_pkg::RSP_STALL;
              end
            end
            usbsre_pkg::REQ_CLEAR_FEAT,
            usbsre_pkg::REQ_SET_FEAT: begin
              if (item_i.request_type == usbsre_pkg::RT_DEV_OUT) begin
                if (val_lo != usbsre_pkg::FEAT_REMOTE_WAKEUP) begin
                  rsp = usbsre_pkg::RSP_STALL;
                end else begin
                  wakeup_d = (item_i.request_code == usbsre_pkg::REQ_SET_FEAT);
                  rsp      = usbsre_pkg::RSP_ACK;
                end
              end else if (item_i.request_type == usbsre_pkg::RT_EP_OUT) begin
                if (val_lo != usbsre_pkg::FEAT_EP_HALT) begin
                  rsp = usbsre_pkg::RSP_ACK;
                end else if (ep == 4'd0 || !ep_in_range) begin
                  rsp = usbsre_pkg::RSP_STALL;
                end else begin
                  // Disabled endpoints ack without effect
                  if (ep_enabled) begin
                    if (item_i.request_code == usbsre_pkg::REQ_SET_FEAT) begin
                      halt_d[ep_sel] = 1'b1;
                    end else begin
                      halt_d[ep_sel] = 1'b0;
                      ep_rst         = ep;
                    end
                  end
                  rsp = usbsre_pkg::RSP_ACK;
                end
              end else begin
                rsp = usbsre_pkg::RSP_STALL;
              end
            end
            usbsre_pkg::REQ_SET_ADDRESS: begin
              if (item_i.request_type != usbsre_pkg::RT_DEV_OUT) begin
                rsp = usbsre_pkg::RSP_STALL;
              end else begin
                address_d = 7'(item_i.request_value & usbsre_pkg::ADDR_MASK);
                if (address_d != 7'd0) begin
                  state_d = usbsre_pkg::ST_ADDRESSED;
                end else begin
                  state_d = usbsre_pkg::ST_DEFAULT;
                end
                rsp       = usbsre_pkg::RSP_ACK;
              end
            end
            usbsre_pkg::REQ_GET_DESC: begin
              if (item_i.request_type == usbsre_pkg::RT_DEV_IN ||
                  item_i.request_type == usbsre_pkg::RT_IFC_IN) begin
                rsp = usbsre_pkg::RSP_FORWARD;
              end else begin
                rsp = usbsre_pkg::RSP_STALL;
              end
            end
            usbsre_pkg::REQ_GET_CONFIG: begin
              if (item_i.request_type != usbsre_pkg::RT_DEV_IN) begin
                rsp = usbsre_pkg::RSP_STALL;
              end else begin
                data = {8'd0, config_q};
                len  = 2'd1;
                rsp  = usbsre_pkg::RSP_DATA;
              end
            end
            usbsre_pkg::REQ_SET_CONFIG: begin
              if (item_i.request_type != usbsre_pkg::RT_DEV_OUT ||
                  val_lo > max_config_q) begin
                rsp = usbsre_pkg::RSP_STALL;
              end else begin
                config_d = val_lo;
                halt_d   = '0;
                // Configuration zero falls back to addressed or powered
                if (val_lo != 8'd0) begin
                  state_d = usbsre_pkg::ST_CONFIGURED;
                end else if (address_q != 7'd0) begin
                  state_d = usbsre_pkg::ST_ADDRESSED;
                end else begin
                  state_d = usbsre_pkg::ST_POWERED;
                end
                cfg_pulse = 1'b1;
                rsp       = usbsre_pkg::RSP_ACK;
              end
            end
            default: begin
              rsp = usbsre_pkg::RSP_STALL;
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result_o.device_state          = state_d;
    result_o.response              = rsp;
    result_o.reply_data            = data;
    result_o.reply_length          = len;
    result_o.device_address        = address_d;
    result_o.configuration_number  = config_d;
    result_o.remote_wakeup_enabled = wakeup_d;
    result_o.pll_enable            = pll_d;
    result_o.clock_frozen          = frozen_d;
    result_o.endpoint_reset        = ep_rst;
    result_o.configure_pulse       = cfg_pulse;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      self_powered_q <= 1'b0;
      max_config_q   <= 8'd1;
      manual_clock_q <= 1'b0;
      ep_enable_q    <= 8'd1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        usbsre_pkg::CFG_SELF_POWERED: self_powered_q <= cfg_data_i[0];
        usbsre_pkg::CFG_MAX_CONFIG:   max_config_q   <= cfg_data_i;
        usbsre_pkg::CFG_MANUAL_CLOCK: manual_clock_q <= cfg_data_i[0];
        usbsre_pkg::CFG_EP_ENABLE:    ep_enable_q    <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= usbsre_pkg::ST_UNATTACHED;
      address_q    <= 7'd0;
      config_q     <= 8'd0;
      wakeup_q     <= 1'b0;
      halt_q       <= '0;
      susp_armed_q <= 1'b1;
      wake_armed_q <= 1'b0;
      pll_q        <= 1'b0;
      frozen_q     <= 1'b0;
    end else if (go_i) begin
      state_q      <= state_d;
      address_q    <= address_d;
      config_q     <= config_d;
      wakeup_q     <= wakeup_d;
      halt_q       <= halt_d;
      susp_armed_q <= susp_armed_d;
      wake_armed_q <= wake_armed_d;
      pll_q        <= pll_d;
      frozen_q     <= frozen_d;
    end
  end

endmodule

>>> src/usbsre_output_stage.sv
// Result register: holds one result transfer until the receiver takes it.
module usbsre_output_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  usbsre_pkg::result_t  result_i,
  output logic                 ready_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output usbsre_pkg::result_t  result_o
);

  logic                vld_q, vld_d;
  usbsre_pkg::result_t result_q;

  // Free when empty or when the held result leaves this cycle
  assign ready_o = ~vld_q | ~out_stall_i;

  always_comb begin
    vld_d = vld_q;
    if (load_i) begin
      vld_d = 1'b1;
    end else if (!out_stall_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = vld_q;
  assign result_o    = result_q;

endmodule

>>> src/usbsre_checker.sv
// Port-level checks on the request engine's result transfers, bound to the top level.
module usbsre_props (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_stall_i,
  input logic [2:0]  device_state_i,
  input logic [2:0]  response_i,
  input logic [15:0] reply_data_i,
  input logic [1:0]  reply_length_i,
  input logic [3:0]  endpoint_reset_i,
  input logic        configure_pulse_i
);

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // Reply word and length only accompany a data reply
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && response_i != usbsre_pkg::RSP_DATA |->
      reply_data_i == 16'd0 && reply_length_i == 2'd0)
    else $error("reply payload without data response");

  // Configuration strobe comes only with an acked request in a post-config state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && configure_pulse_i |->
      response_i == usbsre_pkg::RSP_ACK &&
      (device_state_i == usbsre_pkg::ST_CONFIGURED ||
       device_state_i == usbsre_pkg::ST_ADDRESSED ||
       device_state_i == usbsre_pkg::ST_POWERED))
    else $error("configure pulse with wrong response or state");

  // Endpoint reset only on an acked clear-halt
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && endpoint_reset_i != 4'd0 |-> response_i == usbsre_pkg::RSP_ACK)
    else $error("endpoint reset without ack");

  // An unattached device never answers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && device_state_i == usbsre_pkg::ST_UNATTACHED |->
      response_i == usbsre_pkg::RSP_NONE)
    else $error("response while unattached");

endmodule

bind usb_device_standard_request_engine usbsre_props u_props (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_i       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .device_state_i    (device_state_o),
  .response_i        (response_o),
  .reply_data_i      (reply_data_o),
  .reply_length_i    (reply_length_o),
  .endpoint_reset_i  (endpoint_reset_o),
  .configure_pulse_i (configure_pulse_o)
);

>>> test/usbsre_checker.sv
// Scoreboard for the request engine: mirrors its registers, predicts each result and checks it.
module usbsre_checker import usbsre_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  item_t       item_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  result_t     result_i,
  output int unsigned pending_o,
  output int unsigned errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Register copies
  logic       self_powered_q;
  logic [7:0] max_config_q;
  logic       manual_clock_q;
  logic [7:0] ep_enable_q;

  // Device model state
  dev_state_e                state_q;
  logic [6:0]                address_q;
  logic [7:0]                config_q;
  logic                      remote_wakeup_q;
  logic [ENDPOINT_COUNT-1:0] halted_q;
  logic                      suspend_armed_q;
  logic                      wakeup_armed_q;
  logic                      pll_q;
  logic                      frozen_q;

  result_t     expected_results[$];
  int unsigned errors = 0;

  assign errors_o = errors;

  function automatic result_t predict_transfer(item_t it);
    result_t    r;
    logic [7:0] sel;
    logic [3:0] ep;
    logic [EP_IW-1:0] ep_sel;
    logic       ep_in_range;
    logic [15:0] addr_word;
    r           = '0;
    r.response  = RSP_NONE;
    sel         = it.request_value[7:0];
    ep          = it.request_index[3:0];
    ep_sel      = ep[EP_IW-1:0];
    ep_in_range = (ep < ENDPOINT_COUNT);
    case (it.mode)
      MODE_VBUS: begin
        if (!manual_clock_q) pll_q = it.vbus_present;
        if (it.vbus_present) state_q = ST_POWERED;
        else state_q = ST_UNATTACHED;
      end
      MODE_SUSPEND: begin
        if (suspend_armed_q) begin
          suspend_armed_q = 1'b0;
          wakeup_armed_q  = 1'b1;
          frozen_q        = 1'b1;
          if (!manual_clock_q) pll_q = 1'b0;
          state_q = ST_SUSPENDED;
        end
      end
      MODE_WAKEUP: begin
        if (wakeup_armed_q) begin
          if (!manual_clock_q) pll_q = 1'b1;
          frozen_q        = 1'b0;
          wakeup_armed_q  = 1'b0;
          suspend_armed_q = 1'b1;
          if (config_q != 8'd0) state_q = ST_CONFIGURED;
          else if (address_q != 7'd0) state_q = ST_ADDRESSED;
          else state_q = ST_POWERED;
        end
      end
      MODE_RESET: begin
        state_q         = ST_DEFAULT;
        address_q       = '0;
        config_q        = '0;
        halted_q        = '0;
        suspend_armed_q = 1'b0;
        wakeup_armed_q  = 1'b1;
      end
      MODE_SETUP: begin
        // setups are dropped while detached from the bus
        if (state_q != ST_UNATTACHED) begin
          r.response = RSP_STALL;
          case (it.request_code)
            REQ_GET_STATUS: begin
              if (it.request_type == RT_DEV_IN) begin
                r.response     = RSP_DATA;
                r.reply_length = 2'd2;
                r.reply_data   = {14'd0, remote_wakeup_q, self_powered_q};
              end else if (it.request_type == RT_EP_IN && ep_in_range) begin
                r.response     = RSP_DATA;
                r.reply_length = 2'd2;
                r.reply_data   = {15'd0, halted_q[ep_sel]};
              end
            end
            REQ_CLEAR_FEAT, REQ_SET_FEAT: begin
              if (it.request_type == RT_DEV_OUT) begin
                if (sel == FEAT_REMOTE_WAKEUP) begin
                  remote_wakeup_q = (it.request_code == REQ_SET_FEAT);
                  r.response      = RSP_ACK;
                end
              end else if (it.request_type == RT_EP_OUT) begin
                if (sel != FEAT_EP_HALT) begin
                  r.response = RSP_ACK;
                end else if (ep != 4'd0 && ep_in_range) begin
                  r.response = RSP_ACK;
                  // disabled endpoints acknowledge without touching the halt
                  if (ep < 4'd8 && ep_enable_q[ep[2:0]]) begin
                    if (it.request_code == REQ_SET_FEAT) begin
                      halted_q[ep_sel] = 1'b1;
                    end else begin
                      halted_q[ep_sel] = 1'b0;
                      r.endpoint_reset = ep;
                    end
                  end
                end
              end
            end
            REQ_SET_ADDRESS: begin
              if (it.request_type == RT_DEV_OUT) begin
                addr_word  = it.request_value & ADDR_MASK;
                address_q  = addr_word[6:0];
                if (address_q != 7'd0) state_q = ST_ADDRESSED;
                else state_q = ST_DEFAULT;
                r.response = RSP_ACK;
              end
            end
            REQ_GET_DESC: begin
              if (it.request_type == RT_DEV_IN || it.request_type == RT_IFC_IN) begin
                r.response = RSP_FORWARD;
              end
            end
            REQ_GET_CONFIG: begin
              if (it.request_type == RT_DEV_IN) begin
                r.response     = RSP_DATA;
                r.reply_length = 2'd1;
                r.reply_data   = {8'd0, config_q};
              end
            end
            REQ_SET_CONFIG: begin
              if (it.request_type == RT_DEV_OUT && sel <= max_config_q) begin
                config_q = sel;
                halted_q = '0;
                if (config_q != 8'd0) state_q = ST_CONFIGURED;
                else if (address_q != 7'd0) state_q = ST_ADDRESSED;
                else state_q = ST_POWERED;
                r.configure_pulse = 1'b1;
                r.response        = RSP_ACK;
              end
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
    r.device_state          = state_q;
    r.device_address        = address_q;
    r.configuration_number  = config_q;
    r.remote_wakeup_enabled = remote_wakeup_q;
    r.pll_enable            = pll_q;
    r.clock_frozen          = frozen_q;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      self_powered_q  = 1'b0;
      max_config_q    = 8'd1;
      manual_clock_q  = 1'b0;
      ep_enable_q     = 8'd1;
      state_q         = ST_UNATTACHED;
      address_q       = '0;
      config_q        = '0;
      remote_wakeup_q = 1'b0;
      halted_q        = '0;
      suspend_armed_q = 1'b1;
      wakeup_armed_q  = 1'b0;
      pll_q           = 1'b0;
      frozen_q        = 1'b0;
      expected_results.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_SELF_POWERED: self_powered_q = cfg_data_i[0];
          CFG_MAX_CONFIG:   max_config_q   = cfg_data_i;
          CFG_MANUAL_CLOCK: manual_clock_q = cfg_data_i[0];
          CFG_EP_ENABLE:    ep_enable_q    = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) expected_results.push_back(predict_transfer(item_i));
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no request outstanding");
          errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("device_state", 16'(want.device_state),
                      16'(result_i.device_state));
          check_field("response", 16'(want.response), 16'(result_i.response));
          check_field("reply_data", want.reply_data, result_i.reply_data);
          check_field("reply_length", 16'(want.reply_length), 16'(result_i.reply_length));
          check_field("device_address", 16'(want.device_address),
                      16'(result_i.device_address));
          check_field("configuration_number", 16'(want.configuration_number),
                      16'(result_i.configuration_number));
          check_field("remote_wakeup_enabled", 16'(want.remote_wakeup_enabled),
                      16'(result_i.remote_wakeup_enabled));
          check_field("pll_enable", 16'(want.pll_enable), 16'(result_i.pll_enable));
          check_field("clock_frozen", 16'(want.clock_frozen), 16'(result_i.clock_frozen));
          check_field("endpoint_reset", 16'(want.endpoint_reset),
                      16'(result_i.endpoint_reset));
          check_field("configure_pulse", 16'(want.configure_pulse),
                      16'(result_i.configure_pulse));
        end
      end
      pending_o <= int'(expected_results.size());
    end
  end

endmodule

>>> test/usb_device_standard_request_engine_tb.sv
// Testbench top: drives bus events, setup packets and register writes, and reports the verdict.
module usb_device_standard_request_engine_tb import usbsre_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PHASES          = 6;
  localparam int unsigned ITEMS_PER_PHASE = 275;
  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned DRAIN_CYCLES    = 6;
  localparam logic [2:0]  MODE_FIRST_UNUSED = MODE_SETUP + 3'd1;
  localparam logic [2:0]  MODE_LAST         = 3'd7;

  logic        clk_i;
  logic        rst_ni    = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_index = CFG_SELF_POWERED;
  logic [7:0]  cfg_data  = '0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  item_t       tx_item   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        quiet     = 1'b0;   // no idling on either side while set
  logic [7:0]  max_cfg_now = 8'd1;
  int unsigned pending;
  int unsigned errors;
  int unsigned cycles = 0;

  logic [2:0]  device_state;
  logic [2:0]  response;
  logic [15:0] reply_data;
  logic [1:0]  reply_length;
  logic [6:0]  device_address;
  logic [7:0]  configuration_number;
  logic        remote_wakeup_enabled;
  logic        pll_enable;
  logic        clock_frozen;
  logic [3:0]  endpoint_reset;
  logic        configure_pulse;
  result_t     observed;

  assign observed = {device_state, response, reply_data, reply_length, device_address,
                     configuration_number, remote_wakeup_enabled, pll_enable, clock_frozen,
                     endpoint_reset, configure_pulse};

  usb_device_standard_request_engine DUT (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .cfg_we_i                (cfg_we),
    .cfg_index_i             (cfg_index),
    .cfg_data_i              (cfg_data),
    .in_valid_i              (in_valid),
    .in_stall_o              (in_stall),
    .mode_i                  (tx_item.mode),
    .vbus_present_i          (tx_item.vbus_present),
    .request_type_i          (tx_item.request_type),
    .request_code_i          (tx_item.request_code),
    .request_value_i         (tx_item.request_value),
    .request_index_i         (tx_item.request_index),
    .out_valid_o             (out_valid),
    .out_stall_i             (out_stall),
    .device_state_o          (device_state),
    .response_o              (response),
    .reply_data_o            (reply_data),
    .reply_length_o          (reply_length),
    .device_address_o        (device_address),
    .configuration_number_o  (configuration_number),
    .remote_wakeup_enabled_o (remote_wakeup_enabled),
    .pll_enable_o            (pll_enable),
    .clock_frozen_o          (clock_frozen),
    .endpoint_reset_o        (endpoint_reset),
    .configure_pulse_o       (configure_pulse)
  );

  usbsre_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .item_i      (tx_item),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .result_i    (observed),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("usb_device_standard_request_engine test failed");
      $finish;
    end
  end

  // Result side: stall at random before each result transfer while quiet is clear.
  initial begin
    int unsigned hold;
    @(posedge rst_ni);
    forever begin
      hold = quiet ? 0 : $urandom_range(0, 3);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      @(posedge clk_i);
      while (!out_valid) @(posedge clk_i);
    end
  end

  function automatic item_t bus_event(input logic [2:0] m, input logic vbus);
    item_t it;
    it              = '0;
    it.mode         = m;
    it.vbus_present = vbus;
    return it;
  endfunction

  function automatic item_t setup(input logic [7:0] rt, input logic [7:0] rc,
                                  input logic [15:0] val, input logic [15:0] idx);
    item_t it;
    it               = '0;
    it.mode          = MODE_SETUP;
    it.request_type  = rt;
    it.request_code  = rc;
    it.request_value = val;
    it.request_index = idx;
    return it;
  endfunction

  function automatic item_t rand_item();
    item_t       it;
    int unsigned pick;
    logic        coin;
    it.mode          = MODE_SETUP;
    it.vbus_present  = 1'($urandom);
    it.request_type  = 8'($urandom);
    it.request_code  = 8'($urandom);
    it.request_value = 16'($urandom);
    it.request_index = 16'($urandom);
    coin             = 1'($urandom);
    pick             = $urandom_range(0, 99);
    if (pick < 3) begin
      it.mode         = MODE_VBUS;
      it.vbus_present = ($urandom_range(0, 4) != 0);
    end else if (pick < 7) begin
      it.mode = MODE_SUSPEND;
    end else if (pick < 11) begin
      it.mode = MODE_WAKEUP;
    end else if (pick < 14) begin
      it.mode = MODE_RESET;
    end else if (pick < 16) begin
      it.mode = 3'($urandom_range(MODE_FIRST_UNUSED, MODE_LAST));
    end else begin
      if ($urandom_range(0, 4) != 0) it.request_index[3:0] = 4'($urandom_range(0, 8));
      case ($urandom_range(0, 7))
        0: begin
          it.request_code = REQ_GET_STATUS;
          it.request_type = coin ? RT_DEV_IN : RT_EP_IN;
        end
        1, 2: begin
          it.request_code = coin ? REQ_SET_FEAT : REQ_CLEAR_FEAT;
          it.request_type = $urandom_range(0, 1) ? RT_DEV_OUT : RT_EP_OUT;
          if ($urandom_range(0, 3) != 0)
            it.request_value[7:0] = $urandom_range(0, 1) ? FEAT_EP_HALT : FEAT_REMOTE_WAKEUP;
        end
        3: begin
          it.request_code = REQ_SET_ADDRESS;
          it.request_type = RT_DEV_OUT;
          if (coin) it.request_value = 16'($urandom_range(0, 3));
        end
        4: begin
          it.request_code = REQ_GET_DESC;
          it.request_type = coin ? RT_DEV_IN : RT_IFC_IN;
        end
        5: begin
          it.request_code = REQ_GET_CONFIG;
          it.request_type = RT_DEV_IN;
        end
        6: begin
          it.request_code = REQ_SET_CONFIG;
          it.request_type = RT_DEV_OUT;
          if (max_cfg_now != 8'hFF)
            it.request_value[7:0] = 8'($urandom_range(0, int'(max_cfg_now) + 1));
        end
        default: ;
      endcase
      // corrupt the type now and then
      if ($urandom_range(0, 9) == 0) it.request_type = 8'($urandom);
    end
    return it;
  endfunction

  task automatic send(input item_t it);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    tx_item  <= it;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_regs(input logic sp, input logic [7:0] maxc, input logic man,
                            input logic [7:0] mask);
    logic [1:0] idx [4];
    logic [7:0] vals [4];
    idx  = '{CFG_SELF_POWERED, CFG_MAX_CONFIG, CFG_MANUAL_CLOCK, CFG_EP_ENABLE};
    vals = '{{7'd0, sp}, maxc, {7'd0, man}, mask};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      @(posedge clk_i);
    end
    cfg_we      <= 1'b0;
    max_cfg_now = maxc;
  endtask

  initial begin
    logic       sp_set   [PHASES];
    logic [7:0] max_set  [PHASES];
    logic       man_set  [PHASES];
    logic [7:0] mask_set [PHASES];
    sp_set   = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'($urandom)};
    max_set  = '{8'd1, 8'hFF, 8'd0, 8'd3, 8'hFF, 8'($urandom)};
    man_set  = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'($urandom)};
    mask_set = '{8'h01, 8'hFF, 8'h00, 8'hAA, 8'hFE, 8'($urandom)};

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed transfers with the reset register values
    send(setup(RT_DEV_IN, REQ_GET_STATUS, 16'h0000, 16'h0000));
    send(bus_event(MODE_LAST, 1'b0));
    send(bus_event(MODE_FIRST_UNUSED, 1'b1));
    send(bus_event(MODE_VBUS, 1'b1));
    send(bus_event(MODE_WAKEUP, 1'b0));
    send(bus_event(MODE_SUSPEND, 1'b0));
    send(bus_event(MODE_SUSPEND, 1'b0));
    send(bus_event(MODE_WAKEUP, 1'b0));
    send(bus_event(MODE_RESET, 1'b0));
    send(setup(RT_DEV_OUT, REQ_SET_ADDRESS, 16'hFFFF, 16'hFFFF));
    send(setup(RT_DEV_IN, REQ_GET_STATUS, 16'h0000, 16'h0000));
    send(setup(RT_EP_IN, REQ_GET_STATUS, 16'h0000, 16'h000F));
    send(setup(RT_IFC_IN, REQ_GET_STATUS, 16'h0000, 16'h0000));
    send(setup(RT_DEV_OUT, REQ_SET_FEAT, {8'h00, FEAT_REMOTE_WAKEUP}, 16'h0000));
    send(setup(RT_DEV_OUT, REQ_SET_FEAT, 16'h0002, 16'h0000));
    send(setup(RT_DEV_OUT, REQ_SET_CONFIG, 16'h0001, 16'h0000));
    send(setup(RT_DEV_OUT, REQ_SET_CONFIG, 16'h00FF, 16'h0000));
    send(setup(RT_EP_OUT, REQ_SET_FEAT, {8'h00, FEAT_EP_HALT}, 16'h0001));
    send(setup(RT_EP_OUT, REQ_SET_FEAT, {8'h00, FEAT_EP_HALT}, 16'h0000));
    send(setup(RT_EP_OUT, REQ_CLEAR_FEAT, 16'h0005, 16'h0003));
    send(setup(RT_DEV_IN, REQ_GET_DESC, 16'h0100, 16'h0000));
    send(setup(RT_IFC_IN, REQ_GET_DESC, 16'h2200, 16'h0000));
    send(setup(8'h21, REQ_GET_DESC, 16'h0100, 16'h0000));
    send(setup(RT_DEV_IN, REQ_GET_CONFIG, 16'h0000, 16'h0000));
    send(setup(8'h40, 8'hFF, 16'hFFFF, 16'hFFFF));
    send(setup(RT_DEV_OUT, REQ_SET_CONFIG, 16'h0000, 16'h0000));
    send(bus_event(MODE_VBUS, 1'b0));
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      write_regs(sp_set[p], max_set[p], man_set[p], mask_set[p]);
      quiet = (p == 2);
      send(bus_event(MODE_VBUS, 1'b1));
      for (int n = 1; n < ITEMS_PER_PHASE; n++) begin
        send(rand_item());
        // let the pipeline empty completely halfway through each phase
        if (n == ITEMS_PER_PHASE / 2) wait_idle();
      end
      wait_idle();
    end
    quiet = 1'b0;

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("usb_device_standard_request_engine test passed");
    end else begin
      $display("usb_device_standard_request_engine test failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/usbsre_pkg.sv
src/usbsre_input_stage.sv
src/usbsre_engine.sv
src/usbsre_output_stage.sv
src/usb_device_standard_request_engine.sv
src/usbsre_checker.sv
test/usbsre_checker.sv
test/usb_device_standard_request_engine_tb.sv
